// ===== rtl/tei_pkg.sv =====
// shared constants, widths and types for the tensor eigen invariants pipeline
// no dependencies; imported by tensor_eigen_invariants_core
package tei_pkg;

  localparam int FRACTION_BITS = 16;

  localparam int IN_W  = 112;
  localparam int OUT_W = 160;

  // datapath widths
  localparam int D_W    = 68;                  // sum of squared differences
  localparam int S_W    = 64;                  // sum of squared eigenvalues
  localparam int NUM_W  = 98;                  // 27abc and |t|^3
  localparam int N3_W   = 99;                  // product of the three deviations
  localparam int DEN3_W = 36 + FRACTION_BITS;  // 9|t| scaled

  // fa divider: 62 quotient bits, then a 31 step root
  localparam int FA_QB         = 62;
  localparam int FA_RW         = S_W + FA_QB;
  localparam int FA_CW         = 128;
  localparam int FA_SHIFT      = 2 * FRACTION_BITS - 1;
  localparam int FA_SAT_SHIFT  = 63 - 2 * FRACTION_BITS;
  localparam int SQ_STEPS      = 31;
  localparam int SQ_W          = 62;

  // vr and skew dividers share 32 quotient bits, capped at 2^32
  localparam int VR_QB        = 32;
  localparam int VR_RW        = NUM_W + VR_QB;
  localparam int VR_SAT_SHIFT = 32 - FRACTION_BITS;
  localparam int SK_RW        = DEN3_W + VR_QB;

  localparam int RES_POS  = VR_QB + 1;
  localparam int LAST_POS = FA_QB + SQ_STEPS;

  // floor(x/3) = (x * RECIP3) >> RECIP3_SHIFT for x below 2^33
  localparam logic [32:0] RECIP3       = 33'd5726623062;
  localparam int          RECIP3_SHIFT = 34;

  localparam logic [2:0] SEL_ALL = 3'd0;
  localparam logic [2:0] SEL_FA  = 3'd1;
  localparam logic [2:0] SEL_RA  = 3'd2;
  localparam logic [2:0] SEL_VR  = 3'd3;
  localparam logic [2:0] SEL_MD  = 3'd4;
  localparam logic [2:0] SEL_SK  = 3'd5;

  localparam logic CFG_SELECT = 1'b0;
  localparam logic CFG_MASKED = 1'b1;

  typedef struct packed {
    logic               mask_pos;
    logic               s_zero;
    logic               t_zero;
    logic               neg_vr;
    logic               neg_sk;
    logic               fa_sat;
    logic               vr_sat;
    logic               sk_sat;
    logic signed [31:0] md;
  } ctl_t;

  typedef struct packed {
    logic signed [31:0] vr;
    logic signed [31:0] sk;
  } res_t;

endpackage

// ===== rtl/tensor_eigen_invariants_core.sv =====
// tensor eigen invariants: fa, ra, volume ratio, md and skew per voxel
// depends on tei_pkg
//
// One voxel request is accepted every cycle while the output side takes results;
// each result leaves in the order of its request. The pipeline depth is set by the
// fractional anisotropy path: six front stages of subtract, multiply and sum,
// one stage of range checks, a 62 stage restoring divider that retires one
// quotient bit per stage, and a 31 stage square root. The volume ratio and skew
// dividers run 32 stages beside it. All stages advance together and hold when
// the output register is full and not taken. Input tdata packs eigen_first,
// eigen_second, eigen_third and mask_sample from the lowest bit up; output
// tdata packs the five measures, and tuser carries division_fault.
module tensor_eigen_invariants_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  // eigen_first, eigen_second, eigen_third, mask_sample
  input  logic [tei_pkg::IN_W-1:0]   s_tdata,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // first_value, second_value, third_value, fourth_value, fifth_value
  output logic [tei_pkg::OUT_W-1:0]  m_tdata,
  // division_fault
  output logic [0:0]                 m_tuser,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [31:0]                cfg_data
);
  import tei_pkg::*;

  function automatic logic [33:0] absv(input logic signed [34:0] x);
    absv = x[34] ? 34'(-x) : 34'(x);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [34:0] x);
    if (x > 35'sd2147483647) sat32 = 32'sh7fffffff;
    else if (x < -35'sd2147483648) sat32 = 32'sh80000000;
    else sat32 = 32'(x);
  endfunction

  logic               en;
  logic [2:0]         measure_select;
  logic signed [31:0] masked_value;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      measure_select <= SEL_ALL;
      masked_value   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SELECT: measure_select <= cfg_data[2:0];
        CFG_MASKED: masked_value   <= signed'(cfg_data);
        default: ;
      endcase
    end
  end

  // front valid bits, stages 1 to 6
  logic [6:1] fv;
  always_ff @(posedge clk) begin
    if (rst) fv <= '0;
    else if (en) fv <= {fv[5:1], s_tvalid};
  end

  // stage 1: sums and differences
  logic signed [31:0] x_a, x_b, x_c;
  logic signed [15:0] x_m;
  assign x_a = signed'(s_tdata[31:0]);
  assign x_b = signed'(s_tdata[63:32]);
  assign x_c = signed'(s_tdata[95:64]);
  assign x_m = signed'(s_tdata[111:96]);

  logic signed [31:0] a1, b1, c1;
  logic signed [33:0] t1, e1_1, e2_1, e3_1;
  logic signed [32:0] dab1, dbc1, dac1;
  logic               mask1;
  always_ff @(posedge clk) begin
    if (en) begin
      a1    <= x_a;
      b1    <= x_b;
      c1    <= x_c;
      t1    <= 34'(x_a) + 34'(x_b) + 34'(x_c);
      e1_1  <= (34'(x_a) <<< 1) - 34'(x_b) - 34'(x_c);
      e2_1  <= (34'(x_b) <<< 1) - 34'(x_a) - 34'(x_c);
      e3_1  <= (34'(x_c) <<< 1) - 34'(x_a) - 34'(x_b);
      dab1  <= 33'(x_a) - 33'(x_b);
      dbc1  <= 33'(x_b) - 33'(x_c);
      dac1  <= 33'(x_a) - 33'(x_c);
      mask1 <= x_m > 16'sd0;
    end
  end

  // stage 2: magnitudes and signs
  logic [31:0] ma2, mb2, mc2;
  logic [32:0] mdab2, mdbc2, mdac2, me1_2, me2_2, me3_2, mt2;
  logic        st2;
  ctl_t        c2;
  ctl_t        c2_next;
  always_comb begin
    c2_next          = '0;
    c2_next.mask_pos = mask1;
    c2_next.t_zero   = t1 == '0;
    c2_next.neg_vr   = a1[31] ^ b1[31] ^ c1[31] ^ t1[33];
    c2_next.neg_sk   = e1_1[33] ^ e2_1[33] ^ e3_1[33] ^ t1[33];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      ma2   <= 32'(absv(35'(a1)));
      mb2   <= 32'(absv(35'(b1)));
      mc2   <= 32'(absv(35'(c1)));
      mdab2 <= 33'(absv(35'(dab1)));
      mdbc2 <= 33'(absv(35'(dbc1)));
      mdac2 <= 33'(absv(35'(dac1)));
      me1_2 <= 33'(absv(35'(e1_1)));
      me2_2 <= 33'(absv(35'(e2_1)));
      me3_2 <= 33'(absv(35'(e3_1)));
      mt2   <= 33'(absv(35'(t1)));
      st2   <= t1[33];
      c2    <= c2_next;
    end
  end

  // stage 3: first products
  logic [63:0] sqa3, sqb3, sqc3, mab3;
  logic [65:0] sqab3, sqbc3, sqac3, mtt3, me12_3, mdq3;
  logic [31:0] mc3;
  logic [32:0] mt3, me3_3;
  logic        st3;
  ctl_t        c3;
  always_ff @(posedge clk) begin
    if (en) begin
      sqa3   <= ma2 * ma2;
      sqb3   <= mb2 * mb2;
      sqc3   <= mc2 * mc2;
      mab3   <= ma2 * mb2;
      sqab3  <= mdab2 * mdab2;
      sqbc3  <= mdbc2 * mdbc2;
      sqac3  <= mdac2 * mdac2;
      mtt3   <= mt2 * mt2;
      me12_3 <= me1_2 * me2_2;
      mdq3   <= mt2 * RECIP3;
      mc3    <= mc2;
      mt3    <= mt2;
      me3_3  <= me3_2;
      st3    <= st2;
      c3     <= c2;
    end
  end

  // stage 4: sums, partial products of the triple products, mean diffusivity
  logic [S_W-1:0] s4;
  logic [D_W-1:0] d4;
  logic [65:0]    cl4, ch4, el4, eh4;
  logic [63:0]    al4, ah4;
  logic [35:0]    den9_4;
  logic [31:0]    mdm;
  ctl_t           c4;
  ctl_t           c4_next;
  assign mdm = mdq3[RECIP3_SHIFT +: 32];
  always_comb begin
    c4_next    = c3;
    c4_next.md = st3 ? 32'(-{1'b0, mdm}) : signed'(mdm);
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s4     <= sqa3 + sqb3 + sqc3;
      d4     <= D_W'(sqab3) + D_W'(sqbc3) + D_W'(sqac3);
      cl4    <= mtt3[32:0] * mt3;
      ch4    <= mtt3[65:33] * mt3;
      al4    <= mab3[31:0] * mc3;
      ah4    <= mab3[63:32] * mc3;
      el4    <= me12_3[32:0] * me3_3;
      eh4    <= me12_3[65:33] * me3_3;
      den9_4 <= 36'(mt3) + (36'(mt3) << 3);
      c4     <= c4_next;
    end
  end

  // stage 5: recombine partial products
  logic [NUM_W-1:0]  cube5;
  logic [95:0]       abc5;
  logic [N3_W-1:0]   num3_5;
  logic [DEN3_W-1:0] den3_5;
  logic [S_W-1:0]    s5;
  logic [D_W-1:0]    d5;
  ctl_t              c5;
  ctl_t              c5_next;
  always_comb begin
    c5_next        = c4;
    c5_next.s_zero = s4 == '0;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      cube5  <= NUM_W'(cl4) + (NUM_W'(ch4) << 33);
      abc5   <= 96'(al4) + (96'(ah4) << 32);
      num3_5 <= N3_W'(el4) + (N3_W'(eh4) << 33);
      den3_5 <= DEN3_W'(den9_4) << FRACTION_BITS;
      s5     <= s4;
      d5     <= d4;
      c5     <= c5_next;
    end
  end

  // stage 6: times 27
  logic [NUM_W-1:0]  num1_6, cube6;
  logic [N3_W-1:0]   num3_6;
  logic [DEN3_W-1:0] den3_6;
  logic [S_W-1:0]    s6;
  logic [D_W-1:0]    d6;
  ctl_t              c6;
  always_ff @(posedge clk) begin
    if (en) begin
      num1_6 <= (NUM_W'(abc5) << 4) + (NUM_W'(abc5) << 3) + (NUM_W'(abc5) << 1)
                + NUM_W'(abc5);
      cube6  <= cube5;
      num3_6 <= num3_5;
      den3_6 <= den3_5;
      s6     <= s5;
      d6     <= d5;
      c6     <= c5;
    end
  end

  // divider section, positions 0 to LAST_POS
  logic [LAST_POS:0]  vld;
  ctl_t               ctl   [0:LAST_POS];
  logic [FA_RW-1:0]   fa_r  [0:FA_QB];
  logic [S_W-1:0]     fa_d  [0:FA_QB];
  logic [FA_QB-1:0]   fa_q  [0:FA_QB];
  logic [VR_RW-1:0]   vr_r  [0:VR_QB];
  logic [NUM_W-1:0]   vr_d  [0:VR_QB];
  logic [VR_QB-1:0]   vr_q  [0:VR_QB];
  logic [SK_RW-1:0]   sk_r  [0:VR_QB];
  logic [DEN3_W-1:0]  sk_d  [0:VR_QB];
  logic [VR_QB-1:0]   sk_q  [0:VR_QB];
  logic [SQ_W-1:0]    sq_rem [1:SQ_STEPS];
  logic [SQ_W-1:0]    sq_res [1:SQ_STEPS];
  res_t               res   [RES_POS:LAST_POS];

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[LAST_POS-1:0], fv[6]};
  end

  // position 0: range checks and remainder load
  ctl_t ctl0_next;
  always_comb begin
    ctl0_next        = c6;
    ctl0_next.fa_sat = FA_CW'(d6) >= (FA_CW'(s6) << FA_SAT_SHIFT);
    ctl0_next.vr_sat = VR_RW'(num1_6) >= (VR_RW'(cube6) << VR_SAT_SHIFT);
    ctl0_next.sk_sat = num3_6 >= N3_W'({den3_6, {VR_QB{1'b0}}});
  end
  always_ff @(posedge clk) begin
    if (en) begin
      ctl[0]  <= ctl0_next;
      fa_r[0] <= FA_RW'(d6) << FA_SHIFT;
      fa_d[0] <= s6;
      fa_q[0] <= '0;
      vr_r[0] <= VR_RW'(num1_6) << FRACTION_BITS;
      vr_d[0] <= cube6;
      vr_q[0] <= '0;
      sk_r[0] <= SK_RW'(num3_6);
      sk_d[0] <= den3_6;
      sk_q[0] <= '0;
    end
  end

  for (genvar p = 1; p <= LAST_POS; p++) begin : g_ctl
    always_ff @(posedge clk) begin
      if (en) ctl[p] <= ctl[p-1];
    end
  end

  // fa restoring divider, one quotient bit per stage
  for (genvar j = 0; j < FA_QB; j++) begin : g_fa
    localparam int K = FA_QB - 1 - j;
    logic [FA_RW-1:0] dsh;
    logic             take;
    assign dsh  = FA_RW'(fa_d[j]) << K;
    assign take = fa_r[j] >= dsh;
    always_ff @(posedge clk) begin
      if (en) begin
        fa_r[j+1] <= take ? fa_r[j] - dsh : fa_r[j];
        fa_d[j+1] <= fa_d[j];
        fa_q[j+1] <= {fa_q[j][FA_QB-2:0], take};
      end
    end
  end

  // vr and skew dividers
  for (genvar j = 0; j < VR_QB; j++) begin : g_vs
    localparam int K = VR_QB - 1 - j;
    logic [VR_RW-1:0] vsh;
    logic [SK_RW-1:0] ssh;
    logic             vtake, stake;
    assign vsh   = VR_RW'(vr_d[j]) << K;
    assign ssh   = SK_RW'(sk_d[j]) << K;
    assign vtake = vr_r[j] >= vsh;
    assign stake = sk_r[j] >= ssh;
    always_ff @(posedge clk) begin
      if (en) begin
        vr_r[j+1] <= vtake ? vr_r[j] - vsh : vr_r[j];
        vr_d[j+1] <= vr_d[j];
        vr_q[j+1] <= {vr_q[j][VR_QB-2:0], vtake};
        sk_r[j+1] <= stake ? sk_r[j] - ssh : sk_r[j];
        sk_d[j+1] <= sk_d[j];
        sk_q[j+1] <= {sk_q[j][VR_QB-2:0], stake};
      end
    end
  end

  // signed vr and skew results, capped quotient of 2^32 when saturated
  logic [32:0]        vr_m, sk_m;
  logic signed [34:0] one_q;
  assign vr_m  = ctl[VR_QB].vr_sat ? 33'h100000000 : {1'b0, vr_q[VR_QB]};
  assign sk_m  = ctl[VR_QB].sk_sat ? 33'h100000000 : {1'b0, sk_q[VR_QB]};
  assign one_q = 35'sd1 <<< FRACTION_BITS;
  always_ff @(posedge clk) begin
    if (en) begin
      res[RES_POS].vr <= ctl[VR_QB].neg_vr ? sat32(one_q + signed'(35'(vr_m)))
                                           : sat32(one_q - signed'(35'(vr_m)));
      res[RES_POS].sk <= ctl[VR_QB].neg_sk ? sat32(-signed'(35'(sk_m)))
                                           : sat32(signed'(35'(sk_m)));
    end
  end

  for (genvar p = RES_POS + 1; p <= LAST_POS; p++) begin : g_res
    always_ff @(posedge clk) begin
      if (en) res[p] <= res[p-1];
    end
  end

  // integer square root, two radicand bits per stage
  logic [SQ_W-1:0] sq_in;
  assign sq_in = ctl[FA_QB].fa_sat ? '1 : fa_q[FA_QB];

  for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sq
    localparam logic [SQ_W-1:0] BITV = SQ_W'(1) << (2 * (SQ_STEPS - 1 - j));
    logic [SQ_W-1:0] rin, sin, trial;
    logic            ge;
    if (j == 0) begin : g_first
      assign rin = sq_in;
      assign sin = '0;
    end else begin : g_rest
      assign rin = sq_rem[j];
      assign sin = sq_res[j];
    end
    assign trial = sin + BITV;
    assign ge    = rin >= trial;
    always_ff @(posedge clk) begin
      if (en) begin
        sq_rem[j+1] <= ge ? rin - trial : rin;
        sq_res[j+1] <= ge ? (sin >> 1) + BITV : sin >> 1;
      end
    end
  end

  // measure selection
  ctl_t               cl;
  logic [4:0][31:0]   vals;
  logic [4:0]         flts;
  logic [OUT_W-1:0]   data_next;
  logic               fault_next;
  assign cl = ctl[LAST_POS];

  always_comb begin
    if (cl.mask_pos) begin
      vals[0] = cl.s_zero ? 32'd0 : {1'b0, sq_res[SQ_STEPS][30:0]};
      vals[1] = vals[0];
      vals[2] = cl.t_zero ? 32'd0 : res[LAST_POS].vr;
      vals[3] = cl.md;
      vals[4] = cl.t_zero ? 32'd0 : res[LAST_POS].sk;
      flts    = {cl.t_zero, 1'b0, cl.t_zero, cl.s_zero, cl.s_zero};
    end else begin
      vals = {5{masked_value}};
      flts = '0;
    end
    case (measure_select)
      SEL_FA: begin
        data_next  = {128'd0, vals[0]};
        fault_next = flts[0];
      end
      SEL_RA: begin
        data_next  = {128'd0, vals[1]};
        fault_next = flts[1];
      end
      SEL_VR: begin
        data_next  = {128'd0, vals[2]};
        fault_next = flts[2];
      end
      SEL_MD: begin
        data_next  = {128'd0, vals[3]};
        fault_next = flts[3];
      end
      SEL_SK: begin
        data_next  = {128'd0, vals[4]};
        fault_next = flts[4];
      end
      default: begin
        data_next  = vals;
        fault_next = |flts;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (en) m_tvalid <= vld[LAST_POS];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata    <= data_next;
      m_tuser[0] <= fault_next;
    end
  end

`ifndef ASSERT_OFF
  // excluded voxel never reports a fault
  a_masked_no_fault: assert property (@(posedge clk) disable iff (rst)
    (en && vld[LAST_POS] && !cl.mask_pos) |=> (m_tvalid && !m_tuser[0]))
    else $error("masked voxel reported a division fault");

  // root of a capped quotient stays below 2^31
  a_root_range: assert property (@(posedge clk) disable iff (rst)
    vld[LAST_POS] |-> (sq_res[SQ_STEPS][SQ_W-1:31] == '0))
    else $error("square root result out of range");

  // zero eigenvalue energy in all mode must raise the fault
  a_szero_fault: assert property (@(posedge clk) disable iff (rst)
    (en && vld[LAST_POS] && cl.mask_pos && cl.s_zero && measure_select == SEL_ALL)
    |=> m_tuser[0])
    else $error("zero divisor without fault");
`endif

endmodule

// ===== dv/testbench.sv =====
// self-checking testbench for tensor_eigen_invariants_core: streams voxel requests,
// predicts md, fa, ra, volume ratio and skew in wide integer math and checks each result
// depends on tei_pkg and tensor_eigen_invariants_core
`timescale 1ns / 1ps

module testbench;
  import tei_pkg::*;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [IN_W-1:0]    s_tdata = '0;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [OUT_W-1:0]   m_tdata;
  logic [0:0]         m_tuser;
  logic               cfg_we = 1'b0;
  logic               cfg_index = CFG_SELECT;
  logic [31:0]        cfg_data = '0;

  typedef struct packed {
    logic        fault;
    logic [31:0] v5, v4, v3, v2, v1;
  } invariants_t;

  logic [IN_W-1:0] voxel_queue[$];
  invariants_t     expected_invariants[$];
  logic [2:0]      sel_shadow = SEL_ALL;
  logic [31:0]     masked_shadow = '0;
  int              error_count = 0;
  int              accepted = 0;

  tensor_eigen_invariants_core dut (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic logic [191:0] wide(logic [63:0] x);
    return {128'b0, x};
  endfunction

  function automatic logic [63:0] magnitude(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // quotient magnitude capped at 2^40, then signed
  function automatic longint capped_quot(logic [191:0] q, bit neg);
    longint m;
    if (q > (192'd1 << 40)) m = longint'(64'd1 << 40);
    else m = longint'(q[63:0]);
    return neg ? -m : m;
  endfunction

  function automatic invariants_t predict_invariants(logic [IN_W-1:0] din, logic [2:0] sel,
                                                     logic [31:0] mval);
    longint      a, b, c, t, e1, e2, e3;
    logic [63:0] s, mt;
    logic [191:0] num, den, q;
    longint      val[5];
    bit          flt[5];
    bit          neg, fault;
    int          k;
    invariants_t r;
    a = longint'($signed(din[31:0]));
    b = longint'($signed(din[63:32]));
    c = longint'($signed(din[95:64]));
    for (k = 0; k < 5; k++) flt[k] = 0;
    if ($signed(din[111:96]) > 0) begin
      t = a + b + c;
      s = magnitude(a) * magnitude(a) + magnitude(b) * magnitude(b)
        + magnitude(c) * magnitude(c);
      val[3] = t / 3;
      if (s == 0) begin
        val[0] = 0;
        flt[0] = 1;
        flt[1] = 1;
      end else begin
        num = wide(magnitude(a - b)) * wide(magnitude(a - b))
            + wide(magnitude(b - c)) * wide(magnitude(b - c))
            + wide(magnitude(a - c)) * wide(magnitude(a - c));
        q = (num << (2 * FRACTION_BITS - 1)) / wide(s);
        if (q >= (192'd1 << 62)) val[0] = 64'sd2147483647;
        else val[0] = sat32(longint'(int_sqrt(q[63:0])));
      end
      val[1] = val[0];
      if (t == 0) begin
        val[2] = 0;
        val[4] = 0;
        flt[2] = 1;
        flt[4] = 1;
      end else begin
        mt = magnitude(t);
        den = wide(mt) * wide(mt) * wide(mt);
        num = wide(magnitude(a)) * wide(magnitude(b)) * wide(magnitude(c)) * 192'd27;
        neg = ((a < 0) ^ (b < 0) ^ (c < 0)) != (t < 0);
        q = (num << FRACTION_BITS) / den;
        val[2] = sat32((longint'(1) << FRACTION_BITS) - capped_quot(q, neg));
        e1 = 3 * a - t;
        e2 = 3 * b - t;
        e3 = 3 * c - t;
        num = wide(magnitude(e1)) * wide(magnitude(e2)) * wide(magnitude(e3));
        den = wide((64'd9 * mt) << FRACTION_BITS);
        neg = ((e1 < 0) ^ (e2 < 0) ^ (e3 < 0)) != (t < 0);
        q = num / den;
        val[4] = sat32(capped_quot(q, neg));
      end
    end else begin
      for (k = 0; k < 5; k++) val[k] = longint'($signed(mval));
    end
    fault = 0;
    if (sel == SEL_ALL || sel > SEL_SK) begin
      for (k = 0; k < 5; k++) fault |= flt[k];
      r.v1 = val[0][31:0];
      r.v2 = val[1][31:0];
      r.v3 = val[2][31:0];
      r.v4 = val[3][31:0];
      r.v5 = val[4][31:0];
    end else begin
      r.v1 = val[sel - 1][31:0];
      r.v2 = '0;
      r.v3 = '0;
      r.v4 = '0;
      r.v5 = '0;
      fault = flt[sel - 1];
    end
    r.fault = fault;
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", field, got, want, $realtime);
    error_count++;
  endtask

  // no idling while a band of requests goes through
  function automatic bit take_gap();
    if (accepted >= 400 && accepted < 560) return 0;
    return $urandom_range(99) < 34;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid) begin
        expected_invariants.push_back(predict_invariants(s_tdata, sel_shadow, masked_shadow));
        accepted++;
      end
      if (voxel_queue.size() != 0 && !take_gap()) begin
        s_tvalid <= 1'b1;
        s_tdata  <= voxel_queue.pop_front();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    invariants_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_invariants.size() == 0) begin
          $display("unexpected result %h at %0t", m_tdata, $realtime);
          error_count++;
        end else begin
          want = expected_invariants.pop_front();
          if (m_tdata[31:0] !== want.v1) report_mismatch("first_value", m_tdata[31:0], want.v1);
          if (m_tdata[63:32] !== want.v2)
            report_mismatch("second_value", m_tdata[63:32], want.v2);
          if (m_tdata[95:64] !== want.v3)
            report_mismatch("third_value", m_tdata[95:64], want.v3);
          if (m_tdata[127:96] !== want.v4)
            report_mismatch("fourth_value", m_tdata[127:96], want.v4);
          if (m_tdata[159:128] !== want.v5)
            report_mismatch("fifth_value", m_tdata[159:128], want.v5);
          if (m_tuser[0] !== want.fault)
            report_mismatch("division_fault", 32'(m_tuser[0]), 32'(want.fault));
        end
      end
      m_tready <= !take_gap();
    end
  end

  task automatic write_reg(logic idx, logic [31:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_SELECT) sel_shadow = value[2:0];
    else masked_shadow = value;
  endtask

  task automatic drain();
    while (voxel_queue.size() != 0 || expected_invariants.size() != 0 || s_tvalid)
      @(posedge clk);
    repeat (110) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_eigen();
    logic [31:0] e;
    case ($urandom_range(9))
      0: e = 32'h7fffffff;
      1: e = 32'h80000000;
      2: e = 32'd0;
      3, 4: e = $urandom_range(32'h0008_0000);
      5: e = -$urandom_range(32'h0002_0000);
      default: e = $urandom;
    endcase
    return e;
  endfunction

  function automatic logic [IN_W-1:0] rand_voxel();
    logic [31:0] a, b, c;
    logic [15:0] m;
    a = rand_eigen();
    b = rand_eigen();
    c = rand_eigen();
    case ($urandom_range(9))
      0: c = -(a + b);               // zero trace
      1: begin b = a; c = a; end     // isotropic
      2: begin a = 0; b = 0; c = 0; end
      default: ;
    endcase
    case ($urandom_range(7))
      0: m = 16'($urandom);
      1: m = -16'($urandom_range(32768));
      default: m = 16'($urandom_range(32767, 1));
    endcase
    return {m, c, b, a};
  endfunction

  logic [2:0]  sel_list[9]    = '{SEL_ALL, SEL_FA, SEL_RA, SEL_VR, SEL_MD, SEL_SK, 3'd6, 3'd7,
                                  SEL_ALL};
  logic [31:0] masked_list[9] = '{32'h7fffffff, 32'h80000000, 32'h0001_0000, 32'hffff_0000,
                                  32'h0, 32'h1234_5678, 32'h7fffffff, 32'h80000000, 32'h0};

  initial begin
    int p, n;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed voxels, default registers
    voxel_queue.push_back({16'd1, 32'd0, 32'd0, 32'd0});
    voxel_queue.push_back({16'h7fff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff});
    voxel_queue.push_back({16'd1, 32'h80000000, 32'h80000000, 32'h80000000});
    voxel_queue.push_back({16'd1, 32'h0, 32'h7fffffff, 32'h80000000});
    voxel_queue.push_back({16'd1, 32'h80000000, 32'h80000000, 32'h7fffffff});
    voxel_queue.push_back({16'd1, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000});
    voxel_queue.push_back({16'd1, 32'h0, 32'h0, 32'h0003_0000});
    voxel_queue.push_back({16'd1, 32'hfffd_0000, 32'h0002_0000, 32'h0001_0000});
    voxel_queue.push_back({16'd5, 32'h0000_4000, 32'h0000_8000, 32'h0001_0000});
    voxel_queue.push_back({16'd1, 32'hffff_ffff, 32'h0, 32'h1});
    voxel_queue.push_back({16'd0, 32'h1, 32'h2, 32'h3});
    voxel_queue.push_back({16'h8000, 32'h1, 32'h2, 32'h3});
    voxel_queue.push_back({16'hffff, 32'h7fffffff, 32'h0, 32'h0});
    voxel_queue.push_back({16'd1, 32'h1, 32'h1, 32'hfffffffe});
    voxel_queue.push_back({16'd1, 32'h7fffffff, 32'h7fffffff, 32'h0});
    drain();

    for (p = 0; p < 9; p++) begin
      write_reg(CFG_SELECT, {29'($urandom), sel_list[p]});
      write_reg(CFG_MASKED, p == 5 ? $urandom : masked_list[p]);
      for (n = 0; n < 95; n++) voxel_queue.push_back(rand_voxel());
      drain();
    end

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/tei_pkg.sv
rtl/tensor_eigen_invariants_core.sv
dv/testbench.sv
